FILE: rtl/core/timed_event_queue_unit_macros.svh
// Assertion macros shared by the timed event queue RTL.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef TIMED_EVENT_QUEUE_UNIT_MACROS_SVH
`define TIMED_EVENT_QUEUE_UNIT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define TEQU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define TEQU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tequ_pkg.sv
// Types and constants of the timed event queue.
// No dependencies; used by the interfaces and every module of the block.
package tequ_pkg;

    localparam int KIND_W      = 2;
    localparam int KIND_N      = 4;
    localparam int DELAY_W     = 24;
    localparam int TIME_W      = 64;
    localparam int MAX_RESULTS = 4;
    localparam int NRES_W      = 2;
    localparam int DUE_CNT_W   = 3;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [DELAY_W-1:0] t_delay;
    typedef logic [NRES_W-1:0]  t_nres;

    localparam t_time TIME_MAX  = '1;
    localparam t_nres NRES_LAST = NRES_W'(MAX_RESULTS - 1);

    typedef enum logic {
        CMD_SCHEDULE = 1'b0,
        CMD_CHECK    = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FIRED  = 2'd0,
        ST_NONE   = 2'd1,
        ST_SCHED  = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_PUSH
    } t_state;

    typedef struct packed {
        t_status status;
        t_kind   fired_kind;
        t_time   due_time;
        logic    last;
    } t_result;

endpackage

FILE: rtl/core/tequ_if.sv
// Item channels of the timed event queue: command in, result out.
// Depends on tequ_pkg.
interface tequ_in_if;
    import tequ_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_kind  event_kind;
    t_delay delay;
    t_time  now_time;

    modport source (output valid, cmd, event_kind, delay, now_time, input ready);
    modport sink   (input valid, cmd, event_kind, delay, now_time, output ready);
endinterface

interface tequ_out_if;
    import tequ_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_kind   fired_kind;
    t_time   due_time;
    logic    last;

    modport source (output valid, status, fired_kind, due_time, last, input ready);
    modport sink   (input valid, status, fired_kind, due_time, last, output ready);
endinterface

FILE: rtl/core/tequ_dl_mem.sv
// Deadline store: one 64-bit entry per event kind, one write and one read port.
// Read data is registered. Depends on tequ_pkg.
module tequ_dl_mem #(
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  tequ_pkg::t_time          i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output tequ_pkg::t_time          o_rdata
);
    import tequ_pkg::*;

    t_time r_mem [DEPTH];
    t_time r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/tequ_obuf.sv
// Output register of the result channel: holds one result until it is taken.
// Depends on tequ_pkg and tequ_out_if.
module tequ_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tequ_pkg::t_result i_res,
    output logic              o_can_push,
    tequ_out_if.source        o_res
);
    import tequ_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_push = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_push) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_push && i_push) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.status     = r_res.status;
    assign o_res.fired_kind = r_res.fired_kind;
    assign o_res.due_time   = r_res.due_time;
    assign o_res.last       = r_res.last;
endmodule

FILE: rtl/core/tequ_ctrl.sv
// Sequencer of the timed event queue: schedules into the deadline store and
// scans it for due kinds. Depends on tequ_pkg, tequ_in_if and the macro header.
`include "timed_event_queue_unit_macros.svh"

module tequ_ctrl #(
    parameter int NUM_KINDS   = 4,
    parameter int MAX_ENTRIES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tequ_in_if.sink                      i_evt,
    output logic                         o_mem_we,
    output logic [$clog2(NUM_KINDS)-1:0] o_mem_waddr,
    output tequ_pkg::t_time              o_mem_wdata,
    output logic                         o_mem_re,
    output logic [$clog2(NUM_KINDS)-1:0] o_mem_raddr,
    input  tequ_pkg::t_time              i_mem_rdata,
    output logic                         o_push,
    output tequ_pkg::t_result            o_res,
    input  logic                         i_can_push
);
    import tequ_pkg::*;

    localparam int KW = $clog2(NUM_KINDS);
    // Only kinds that the kind field can name are ever pending.
    localparam int SCAN_N = (NUM_KINDS < KIND_N) ? NUM_KINDS : KIND_N;
    localparam logic [KW-1:0] LAST_IDX = KW'(SCAN_N - 1);

    t_state                 r_state, n_state;
    logic [NUM_KINDS-1:0]   r_pending, n_pending;
    logic [3:0]             r_occ, n_occ;
    t_time                  r_now, n_now;
    logic [KW-1:0]          r_idx, n_idx;
    logic                   r_issue, n_issue;
    logic                   r_cmp_v, n_cmp_v;
    logic [KW-1:0]          r_cmp_idx, n_cmp_idx;
    logic                   r_best_v, n_best_v;
    logic [KW-1:0]          r_best_idx, n_best_idx;
    t_time                  r_best_dl, n_best_dl;
    logic [DUE_CNT_W-1:0]   r_due_cnt, n_due_cnt;
    t_nres                  r_nres, n_nres;
    t_result                r_res, n_res;

    logic                   accept;
    logic                   kind_ok;
    logic                   room;
    logic [TIME_W:0]        sum;
    t_time                  due;
    logic [KW-1:0]          kidx;
    logic                   hit;
    logic                   fire_last;

    assign i_evt.ready = (r_state == S_IDLE);
    assign accept  = i_evt.valid && i_evt.ready;
    assign kind_ok = 32'(i_evt.event_kind) < 32'(NUM_KINDS);
    assign room    = 32'(r_occ) < 32'(MAX_ENTRIES);
    assign sum     = {1'b0, i_evt.now_time} + (TIME_W + 1)'(i_evt.delay);
    // Saturate at the top of the time range.
    assign due     = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    assign kidx    = KW'(i_evt.event_kind);
    assign hit     = r_cmp_v && r_pending[r_cmp_idx] && (i_mem_rdata <= r_now);
    // Another due kind remains only if this pass saw more than one.
    assign fire_last = (r_due_cnt == DUE_CNT_W'(1)) || (r_nres == NRES_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_occ     <= '0;
            r_issue   <= 1'b0;
            r_cmp_v   <= 1'b0;
            r_nres    <= '0;
        end else begin
            r_pending <= n_pending;
            r_occ     <= n_occ;
            r_issue   <= n_issue;
            r_cmp_v   <= n_cmp_v;
            r_nres    <= n_nres;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_best_v   <= n_best_v;
        r_best_idx <= n_best_idx;
        r_best_dl  <= n_best_dl;
        r_due_cnt  <= n_due_cnt;
        r_res      <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_occ       = r_occ;
        n_now       = r_now;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_cmp_v     = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_best_v    = r_best_v;
        n_best_idx  = r_best_idx;
        n_best_dl   = r_best_dl;
        n_due_cnt   = r_due_cnt;
        n_nres      = r_nres;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = kidx;
        o_mem_wdata = due;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx;
        o_push      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_evt.cmd == CMD_SCHEDULE) begin
                        if (kind_ok && room) begin
                            o_mem_we        = 1'b1;
                            n_pending[kidx] = 1'b1;
                            if (!r_pending[kidx]) begin
                                n_occ = r_occ + 4'd1;
                            end
                            n_res = '{ST_SCHED, i_evt.event_kind, due, 1'b1};
                        end else begin
                            n_res = '{ST_REJECT, i_evt.event_kind, '0, 1'b1};
                        end
                        n_state = S_PUSH;
                    end else begin
                        n_now     = i_evt.now_time;
                        n_nres    = '0;
                        n_idx     = '0;
                        n_issue   = 1'b1;
                        n_best_v  = 1'b0;
                        n_due_cnt = '0;
                        n_state   = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Reads issue one kind a cycle; compare lags by the read latency.
                o_mem_re  = r_issue;
                n_cmp_v   = r_issue;
                n_cmp_idx = r_idx;
                if (r_issue) begin
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + KW'(1);
                    end
                end
                if (hit) begin
                    n_due_cnt = r_due_cnt + DUE_CNT_W'(1);
                    // Strict compare keeps the lower kind on a tie.
                    if (!r_best_v || (i_mem_rdata < r_best_dl)) begin
                        n_best_v   = 1'b1;
                        n_best_idx = r_cmp_idx;
                        n_best_dl  = i_mem_rdata;
                    end
                end
                if (r_cmp_v && (r_cmp_idx == LAST_IDX)) begin
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                if (r_best_v) begin
                    n_res = '{ST_FIRED, KIND_W'(r_best_idx), r_best_dl, fire_last};
                    n_pending[r_best_idx] = 1'b0;
                    n_occ  = r_occ - 4'd1;
                    n_nres = r_nres + NRES_W'(1);
                end else begin
                    n_res = '{ST_NONE, '0, '0, 1'b1};
                end
                n_state = S_PUSH;
            end

            S_PUSH: begin
                o_push = 1'b1;
                if (i_can_push) begin
                    if (r_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx     = '0;
                        n_issue   = 1'b1;
                        n_best_v  = 1'b0;
                        n_due_cnt = '0;
                        n_state   = S_SCAN;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

    `TEQU_ASSERT_ALWAYS(a_occ_matches_pending, i_clk, i_rst_n,
        32'(r_occ) == $countones(r_pending), "occupancy differs from pending count")
    `TEQU_ASSERT_IMPL(a_more_only_after_fire, i_clk, i_rst_n, o_push && !r_res.last,
        r_res.status == ST_FIRED, "non-final result is not a fired event")
    `TEQU_ASSERT_IMPL(a_best_is_pending, i_clk, i_rst_n, (r_state == S_EVAL) && r_best_v,
        r_pending[r_best_idx], "selected kind is not pending")
endmodule

FILE: rtl/core/timed_event_queue_unit.sv
// Timed event queue: holds one deadline per event kind in a small synchronous
// memory. A schedule item writes now_time + delay (saturating) for its kind, or
// is rejected for a bad kind or a full store, and presents its one result through
// the result register and the output register. A check item re-reads the store
// once per result, one kind a cycle through the memory's single read port; fired
// kinds come out earliest deadline first, lower kind on a tie, up to four per
// check, and a check with nothing due yields one "none" result. One item is in
// flight at a time; the next is taken once the last result of the current one
// sits in the output register.
module timed_event_queue_unit #(
    parameter int NUM_KINDS   = 4,
    parameter int MAX_ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tequ_in_if.sink     i_evt,
    tequ_out_if.source  o_res
);
    import tequ_pkg::*;

    localparam int KW = $clog2(NUM_KINDS);

    logic          mem_we;
    logic [KW-1:0] mem_waddr;
    t_time         mem_wdata;
    logic          mem_re;
    logic [KW-1:0] mem_raddr;
    t_time         mem_rdata;
    logic          push;
    t_result       res;
    logic          can_push;

    tequ_dl_mem #(
        .DEPTH (NUM_KINDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tequ_ctrl #(
        .NUM_KINDS   (NUM_KINDS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (i_evt),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_push      (push),
        .o_res       (res),
        .i_can_push  (can_push)
    );

    tequ_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_res      (res),
        .o_can_push (can_push),
        .o_res      (o_res)
    );
endmodule
